// ===== rtl/core/delta_list_timer_queue_assert.svh =====
// ----------------------------------------------------------------------------
// delta_list_timer_queue_assert.svh
// Assertion macros for the delta list timer queue.
// ----------------------------------------------------------------------------
`ifndef DELTA_LIST_TIMER_QUEUE_ASSERT_SVH
`define DELTA_LIST_TIMER_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define DLTQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define DLTQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/dltq_pkg.sv =====
// ----------------------------------------------------------------------------
// dltq_pkg
// Types and codes shared by the delta list timer queue modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dltq_pkg;

    localparam int DELTA_W   = 32;
    localparam int PID_W     = 15;
    localparam int MAX_WAKES = 16;

    localparam logic [1:0] ACT_ADD  = 2'd0;
    localparam logic [1:0] ACT_DEL  = 2'd1;
    localparam logic [1:0] ACT_TICK = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ZERO    = 2'd1;
    localparam logic [1:0] ST_PENDING = 2'd2;
    localparam logic [1:0] ST_NOT_PEN = 2'd3;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_WAKE   = 1'b1;

    typedef struct packed {
        logic [1:0]         action;
        logic [3:0]         timer_slot;
        logic [DELTA_W-1:0] delay_ticks;
        logic [PID_W-1:0]   process_id;
    } t_in_item;

    typedef struct packed {
        logic               kind;
        logic [1:0]         status;
        logic [3:0]         expired_slot;
        logic [PID_W-1:0]   wake_process;
        logic               last;
    } t_out_item;

endpackage

// ===== rtl/core/dltq_mem.sv =====
// ----------------------------------------------------------------------------
// dltq_mem
// Timer entry store: one write port, one read port, registered read data,
// write-first on a same-address collision.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dltq_mem #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 52
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/dltq_seq.sv =====
// ----------------------------------------------------------------------------
// dltq_seq
// List sequencer: walks the delta list in the entry store for add, delete
// and tick, keeps head, pending bits and builds each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dltq_seq #(
    parameter  int NUM_TIMERS = 16,
    localparam int SLOT_W     = $clog2(NUM_TIMERS),
    localparam int ENT_W      = dltq_pkg::DELTA_W + dltq_pkg::PID_W + SLOT_W + 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  dltq_pkg::t_in_item   i_in_item,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output dltq_pkg::t_out_item  o_res,
    output logic                 o_mem_we,
    output logic [SLOT_W-1:0]    o_mem_waddr,
    output logic [ENT_W-1:0]     o_mem_wdata,
    output logic                 o_mem_re,
    output logic [SLOT_W-1:0]    o_mem_raddr,
    input  logic [ENT_W-1:0]     i_mem_rdata
);

    import dltq_pkg::*;

    localparam int CNT_W = $clog2(MAX_WAKES + 1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DEC      = 4'd1;
    localparam logic [3:0] S_ADD_CHK  = 4'd2;
    localparam logic [3:0] S_ADD_WS   = 4'd3;
    localparam logic [3:0] S_ADD_WP   = 4'd4;
    localparam logic [3:0] S_DEL_S    = 4'd5;
    localparam logic [3:0] S_DEL_NX   = 4'd6;
    localparam logic [3:0] S_DEL_LINK = 4'd7;
    localparam logic [3:0] S_DEL_WALK = 4'd8;
    localparam logic [3:0] S_TK_DEC   = 4'd9;
    localparam logic [3:0] S_FIRE     = 4'd10;
    localparam logic [3:0] S_TK_NEXT  = 4'd11;
    localparam logic [3:0] S_PUSH     = 4'd12;

    typedef struct packed {
        logic [DELTA_W-1:0] delta;
        logic [PID_W-1:0]   owner;
        logic [SLOT_W-1:0]  succ;
        logic               succ_vld;
    } t_entry;

    function automatic t_out_item stat_res(input logic [1:0] code);
        t_out_item res;
        res              = '0;
        res.kind         = KIND_STATUS;
        res.status       = code;
        res.last         = 1'b1;
        return res;
    endfunction

    logic [3:0]            r_state, n_state;
    t_in_item              r_item, n_item;
    logic [SLOT_W-1:0]     r_s, n_s;
    logic [DELTA_W-1:0]    r_d, n_d;
    logic [SLOT_W-1:0]     r_cur, n_cur;
    logic                  r_have_cur, n_have_cur;
    logic [SLOT_W-1:0]     r_prev, n_prev;
    logic                  r_have_prev, n_have_prev;
    t_entry                r_ent, n_ent;
    logic [SLOT_W-1:0]     r_head, n_head;
    logic                  r_nonempty, n_nonempty;
    logic [NUM_TIMERS-1:0] r_pending, n_pending;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_more, n_more;
    t_out_item             r_res, n_res;

    t_entry             rd_ent;
    t_entry             wr_ent;
    logic [SLOT_W-1:0]  slot_idx;
    logic               slot_ok;
    logic               d_lt;
    logic [DELTA_W-1:0] rem_cur;
    logic [DELTA_W-1:0] rem_d;
    logic [DELTA_W-1:0] dec_delta;
    logic [CNT_W-1:0]   cnt_inc;

    assign rd_ent    = t_entry'(i_mem_rdata);
    assign slot_idx  = SLOT_W'(r_item.timer_slot);
    assign slot_ok   = (32'(r_item.timer_slot) < 32'(NUM_TIMERS));
    assign d_lt      = (r_d < rd_ent.delta);
    assign rem_cur   = rd_ent.delta - r_d;
    assign rem_d     = r_d - rd_ent.delta;
    assign dec_delta = (rd_ent.delta == '0) ? '0 : rd_ent.delta - DELTA_W'(1);
    assign cnt_inc   = r_cnt + CNT_W'(1);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_PUSH);
    assign o_res       = r_res;
    assign o_mem_wdata = ENT_W'(wr_ent);

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_s         = r_s;
        n_d         = r_d;
        n_cur       = r_cur;
        n_have_cur  = r_have_cur;
        n_prev      = r_prev;
        n_have_prev = r_have_prev;
        n_ent       = r_ent;
        n_head      = r_head;
        n_nonempty  = r_nonempty;
        n_pending   = r_pending;
        n_cnt       = r_cnt;
        n_more      = r_more;
        n_res       = r_res;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_cur;
        wr_ent      = rd_ent;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_cur;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_item;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_s    = slot_idx;
                n_d    = r_item.delay_ticks;
                n_more = 1'b0;
                unique case (r_item.action)
                    ACT_ADD: begin
                        if (r_item.delay_ticks == '0) begin
                            n_res   = stat_res(ST_ZERO);
                            n_state = S_PUSH;
                        end else if (!slot_ok) begin
                            n_res   = stat_res(ST_NOT_PEN);
                            n_state = S_PUSH;
                        end else if (r_pending[slot_idx]) begin
                            n_res   = stat_res(ST_PENDING);
                            n_state = S_PUSH;
                        end else begin
                            n_have_prev = 1'b0;
                            n_have_cur  = r_nonempty;
                            n_cur       = r_head;
                            if (r_nonempty) begin
                                o_mem_re    = 1'b1;
                                o_mem_raddr = r_head;
                                n_state     = S_ADD_CHK;
                            end else begin
                                n_state = S_ADD_WS;
                            end
                        end
                    end
                    ACT_DEL: begin
                        if (!slot_ok || !r_pending[slot_idx]) begin
                            n_res   = stat_res(ST_NOT_PEN);
                            n_state = S_PUSH;
                        end else begin
                            o_mem_re    = 1'b1;
                            o_mem_raddr = slot_idx;
                            n_state     = S_DEL_S;
                        end
                    end
                    ACT_TICK: begin
                        n_cnt = '0;
                        if (r_nonempty) begin
                            o_mem_re    = 1'b1;
                            o_mem_raddr = r_head;
                            n_state     = S_TK_DEC;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_ADD_CHK: begin
                if (d_lt) begin
                    o_mem_we     = 1'b1;
                    o_mem_waddr  = r_cur;
                    wr_ent.delta = rem_cur;
                    n_state      = S_ADD_WS;
                end else begin
                    n_d         = rem_d;
                    n_prev      = r_cur;
                    n_have_prev = 1'b1;
                    n_ent       = rd_ent;
                    n_have_cur  = rd_ent.succ_vld;
                    n_cur       = rd_ent.succ;
                    if (rd_ent.succ_vld) begin
                        o_mem_re    = 1'b1;
                        o_mem_raddr = rd_ent.succ;
                    end else begin
                        n_state = S_ADD_WS;
                    end
                end
            end
            S_ADD_WS: begin
                o_mem_we        = 1'b1;
                o_mem_waddr     = r_s;
                wr_ent.delta    = r_d;
                wr_ent.owner    = r_item.process_id;
                wr_ent.succ     = r_have_cur ? r_cur : '0;
                wr_ent.succ_vld = r_have_cur;
                n_pending[r_s]  = 1'b1;
                if (r_have_prev) begin
                    n_state = S_ADD_WP;
                end else begin
                    n_head     = r_s;
                    n_nonempty = 1'b1;
                    n_res      = stat_res(ST_OK);
                    n_state    = S_PUSH;
                end
            end
            S_ADD_WP: begin
                o_mem_we        = 1'b1;
                o_mem_waddr     = r_prev;
                wr_ent          = r_ent;
                wr_ent.succ     = r_s;
                wr_ent.succ_vld = 1'b1;
                n_res           = stat_res(ST_OK);
                n_state         = S_PUSH;
            end
            S_DEL_S: begin
                n_cur      = rd_ent.succ;
                n_have_cur = rd_ent.succ_vld;
                n_d        = rd_ent.delta;
                if (rd_ent.succ_vld && (rd_ent.delta != '0)) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = rd_ent.succ;
                    n_state     = S_DEL_NX;
                end else begin
                    n_state = S_DEL_LINK;
                end
            end
            S_DEL_NX: begin
                o_mem_we     = 1'b1;
                o_mem_waddr  = r_cur;
                wr_ent.delta = rd_ent.delta + r_d;
                n_state      = S_DEL_LINK;
            end
            S_DEL_LINK: begin
                if (r_nonempty && (r_head != r_s)) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = r_head;
                    n_prev      = r_head;
                    n_state     = S_DEL_WALK;
                end else begin
                    if (r_nonempty) begin
                        n_head     = r_have_cur ? r_cur : '0;
                        n_nonempty = r_have_cur;
                    end
                    n_pending[r_s] = 1'b0;
                    n_res          = stat_res(ST_OK);
                    n_state        = S_PUSH;
                end
            end
            S_DEL_WALK: begin
                if (rd_ent.succ_vld && (rd_ent.succ != r_s)) begin
                    n_prev      = rd_ent.succ;
                    o_mem_re    = 1'b1;
                    o_mem_raddr = rd_ent.succ;
                end else begin
                    if (rd_ent.succ_vld) begin
                        o_mem_we        = 1'b1;
                        o_mem_waddr     = r_prev;
                        wr_ent.succ     = r_have_cur ? r_cur : '0;
                        wr_ent.succ_vld = r_have_cur;
                    end
                    n_pending[r_s] = 1'b0;
                    n_res          = stat_res(ST_OK);
                    n_state        = S_PUSH;
                end
            end
            S_TK_DEC: begin
                if (dec_delta != '0) begin
                    o_mem_we     = 1'b1;
                    o_mem_waddr  = r_head;
                    wr_ent.delta = dec_delta;
                    n_state      = S_IDLE;
                end else begin
                    n_ent   = rd_ent;
                    n_state = S_FIRE;
                end
            end
            S_FIRE: begin
                n_res              = '0;
                n_res.kind         = KIND_WAKE;
                n_res.expired_slot = 4'(r_head);
                n_res.wake_process = r_ent.owner;
                n_pending[r_head]  = 1'b0;
                n_head             = r_ent.succ_vld ? r_ent.succ : '0;
                n_nonempty         = r_ent.succ_vld;
                n_cnt              = cnt_inc;
                if (!r_ent.succ_vld || (cnt_inc == CNT_W'(MAX_WAKES))) begin
                    n_res.last = 1'b1;
                    n_more     = 1'b0;
                    n_state    = S_PUSH;
                end else begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = r_ent.succ;
                    n_state     = S_TK_NEXT;
                end
            end
            S_TK_NEXT: begin
                if (rd_ent.delta == '0) begin
                    n_res.last = 1'b0;
                    n_ent      = rd_ent;
                    n_more     = 1'b1;
                end else begin
                    n_res.last = 1'b1;
                    n_more     = 1'b0;
                end
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (i_res_ready) begin
                    n_state = r_more ? S_FIRE : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_head     <= '0;
            r_nonempty <= 1'b0;
            r_pending  <= '0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_nonempty <= n_nonempty;
            r_pending  <= n_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item      <= n_item;
        r_s         <= n_s;
        r_d         <= n_d;
        r_cur       <= n_cur;
        r_have_cur  <= n_have_cur;
        r_prev      <= n_prev;
        r_have_prev <= n_have_prev;
        r_ent       <= n_ent;
        r_cnt       <= n_cnt;
        r_more      <= n_more;
        r_res       <= n_res;
    end

endmodule

// ===== rtl/core/delta_list_timer_queue.sv =====
// ----------------------------------------------------------------------------
// delta_list_timer_queue
// One-shot timers in a deadline-ordered delta list kept in an entry store,
// with add, delete and tick items and a registered result channel.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      i_in_valid / o_in_ready    i_in_item  (t_in_item)
//   out      output     o_out_valid / i_out_ready  o_out_item (t_out_item)
//
// One item at a time: a new item is taken only once the last one is done.
// Rejected adds and deletes give a status result without touching the store;
// an add walks the entries ahead of its deadline, a delete walks to its
// predecessor; a tick gives no result unless the head expires, and then fires
// each expired head until the list runs out or the 16-wakeup limit ends the
// tick. Reset clears head, pending bits and control only. A full, stalled output
// register holds the sequencer.
`timescale 1ns / 1ps
`include "delta_list_timer_queue_assert.svh"

module delta_list_timer_queue #(
    parameter int NUM_TIMERS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dltq_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output dltq_pkg::t_out_item o_out_item
);

    import dltq_pkg::*;

    localparam int SLOT_W = $clog2(NUM_TIMERS);
    localparam int ENT_W  = DELTA_W + PID_W + SLOT_W + 1;

    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    logic [ENT_W-1:0]  mem_wdata;
    logic              mem_re;
    logic [SLOT_W-1:0] mem_raddr;
    logic [ENT_W-1:0]  mem_rdata;

    logic      seq_res_valid;
    logic      seq_res_ready;
    t_out_item seq_res;

    logic      r_out_valid;
    t_out_item r_out;

    dltq_mem #(
        .DEPTH  (NUM_TIMERS),
        .ADDR_W (SLOT_W),
        .DATA_W (ENT_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    dltq_seq #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_res_valid (seq_res_valid),
        .i_res_ready (seq_res_ready),
        .o_res       (seq_res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    // output register: a transfer out frees it for the next result
    assign seq_res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_res_valid && seq_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_res_valid && seq_res_ready) begin
            r_out <= seq_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `DLTQ_ASSERT_NEXT(a_in_leaves_idle, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "sequencer took an item but stayed ready")
    `DLTQ_ASSERT_NEXT(a_res_captured, i_clk, i_rst_n, seq_res_valid && seq_res_ready, o_out_valid && (o_out_item == $past(seq_res)), "result lost at output register")
    `DLTQ_ASSERT_NOW(a_status_shape, i_clk, i_rst_n, o_out_valid && (o_out_item.kind == KIND_STATUS), o_out_item.last && (o_out_item.expired_slot == '0) && (o_out_item.wake_process == '0), "status result malformed")
    `DLTQ_ASSERT_NOW(a_wake_ok, i_clk, i_rst_n, o_out_valid && (o_out_item.kind == KIND_WAKE), o_out_item.status == ST_OK, "wakeup carries a status code")

endmodule

// ===== test/dltq_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dltq_result_checker
// Watches the input and result channels of the delta list timer queue. It
// keeps its own copy of the ordered timer list, works out the status and
// wakeup results of every accepted transfer, and compares each result
// transfer field by field with the oldest one still awaited.
// ----------------------------------------------------------------------------
module dltq_result_checker #(
    parameter int NUM_TIMERS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  dltq_pkg::t_in_item      i_in_item,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  dltq_pkg::t_out_item     i_out_item,
    output int                      o_fail_count,
    output int                      o_outstanding,
    output int                      o_result_count,
    output int                      o_wake_count,
    output logic [NUM_TIMERS-1:0]   o_armed
);
    import dltq_pkg::*;

    logic               pending   [NUM_TIMERS];
    logic [DELTA_W-1:0] delta     [NUM_TIMERS];
    logic [PID_W-1:0]   owner     [NUM_TIMERS];
    logic [3:0]         next_slot [NUM_TIMERS];
    logic               has_next  [NUM_TIMERS];
    logic [3:0]         head;
    logic               list_live;
    t_out_item          awaited[$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] MISMATCH %s: got %0h, expected %0h", $time, what, got, want);
        o_fail_count++;
    endtask

    // Remove a pending slot from the list; its delta moves to its successor.
    function automatic void detach_slot(input logic [3:0] s);
        logic       follows;
        logic [3:0] nx;
        logic [3:0] p;
        int         n;
        follows = has_next[s];
        nx = next_slot[s];
        if (follows && delta[s] != 0) delta[nx] = delta[nx] + delta[s];
        if (list_live && head == s) begin
            head = follows ? nx : 4'd0;
            list_live = follows;
        end else if (list_live) begin
            p = head;
            for (n = 0; n < NUM_TIMERS; n++) begin
                if (!has_next[p]) break;
                if (next_slot[p] == s) begin
                    has_next[p] = follows;
                    next_slot[p] = follows ? nx : 4'd0;
                    break;
                end
                p = next_slot[p];
            end
        end
        pending[s] = 1'b0;
        has_next[s] = 1'b0;
    endfunction

    // Insert after every entry whose deadline is not later.
    function automatic logic [1:0] arm_slot(input logic [3:0] s,
                                            input logic [DELTA_W-1:0] d_in,
                                            input logic [PID_W-1:0] pid);
        logic [DELTA_W-1:0] d;
        logic               have_prev;
        logic               have_cur;
        logic [3:0]         prev;
        logic [3:0]         cur;
        int                 n;
        d = d_in;
        have_prev = 1'b0;
        have_cur = list_live;
        prev = 4'd0;
        cur = head;
        if (d == 0) return ST_ZERO;
        if (int'(s) >= NUM_TIMERS) return ST_NOT_PEN;
        if (pending[s]) return ST_PENDING;
        for (n = 0; n < NUM_TIMERS && have_cur; n++) begin
            if (d < delta[cur]) begin
                delta[cur] = delta[cur] - d;
                break;
            end
            d = d - delta[cur];
            prev = cur;
            have_prev = 1'b1;
            have_cur = has_next[cur];
            cur = next_slot[cur];
        end
        delta[s] = d;
        owner[s] = pid;
        pending[s] = 1'b1;
        has_next[s] = have_cur;
        next_slot[s] = have_cur ? cur : 4'd0;
        if (have_prev) begin
            has_next[prev] = 1'b1;
            next_slot[prev] = s;
        end else begin
            head = s;
            list_live = 1'b1;
        end
        return ST_OK;
    endfunction

    function automatic void push_status(input logic [1:0] st);
        t_out_item r;
        r = '0;
        r.kind = KIND_STATUS;
        r.status = st;
        r.last = 1'b1;
        awaited.push_back(r);
    endfunction

    function automatic void expire_due();
        t_out_item  wakes [MAX_WAKES];
        t_out_item  r;
        logic [3:0] h;
        int         k;
        int         i;
        k = 0;
        if (list_live) begin
            h = head;
            if (delta[h] != 0) delta[h] = delta[h] - 1;
            while (list_live && k < MAX_WAKES) begin
                h = head;
                if (delta[h] != 0) break;
                r = '0;
                r.kind = KIND_WAKE;
                r.expired_slot = h;
                r.wake_process = owner[h];
                wakes[k] = r;
                k++;
                detach_slot(h);
            end
            if (k > 0) begin
                r = wakes[k-1];
                r.last = 1'b1;
                wakes[k-1] = r;
            end
            for (i = 0; i < k; i++) awaited.push_back(wakes[i]);
        end
    endfunction

    function automatic void apply_transfer(input t_in_item it);
        case (it.action)
            ACT_ADD: begin
                push_status(arm_slot(it.timer_slot, it.delay_ticks, it.process_id));
            end
            ACT_DEL: begin
                if (int'(it.timer_slot) < NUM_TIMERS && pending[it.timer_slot]) begin
                    detach_slot(it.timer_slot);
                    push_status(ST_OK);
                end else begin
                    push_status(ST_NOT_PEN);
                end
            end
            ACT_TICK: begin
                expire_due();
            end
            default: begin
            end
        endcase
    endfunction

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (awaited.size() == 0) begin
            report_mismatch("result transfer with none awaited", 32'(got), 32'd0);
        end else begin
            want = awaited.pop_front();
            o_result_count++;
            if (want.kind == KIND_WAKE) o_wake_count++;
            if (got.kind !== want.kind)
                report_mismatch("kind", 32'(got.kind), 32'(want.kind));
            if (got.status !== want.status)
                report_mismatch("status", 32'(got.status), 32'(want.status));
            if (got.expired_slot !== want.expired_slot)
                report_mismatch("expired_slot", 32'(got.expired_slot),
                                32'(want.expired_slot));
            if (got.wake_process !== want.wake_process)
                report_mismatch("wake_process", 32'(got.wake_process),
                                32'(want.wake_process));
            if (got.last !== want.last)
                report_mismatch("last", 32'(got.last), 32'(want.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
                pending[i] = 1'b0;
                delta[i] = '0;
                owner[i] = '0;
                next_slot[i] = '0;
                has_next[i] = 1'b0;
            end
            head = '0;
            list_live = 1'b0;
            awaited.delete();
            o_fail_count = 0;
            o_result_count = 0;
            o_wake_count = 0;
        end else begin
            if (i_in_valid && i_in_ready) apply_transfer(i_in_item);
            if (i_out_valid && i_out_ready) check_result(i_out_item);
        end
        o_outstanding = awaited.size();
        for (int i = 0; i < NUM_TIMERS; i++) o_armed[i] = pending[i];
    end

endmodule

// ===== test/tb_delta_list_timer_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_delta_list_timer_queue
// Drives add, delete and tick transfers into the timer queue: a directed
// opening on the status codes, ties and list edges, then random traffic of
// armed timers, deletes and ticks under changing sender gaps and receiver
// stalls. The checker beside the block scores every result transfer.
// ----------------------------------------------------------------------------
module tb_delta_list_timer_queue;
    import dltq_pkg::*;

    localparam int         NUM_TIMERS    = 16;
    localparam int         RANDOM_ITEMS  = 230;
    localparam int         CYCLE_LIMIT   = 400000;
    localparam int         SETTLE_CYCLES = 48;
    localparam logic [1:0] ACT_UNUSED    = 2'd3;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_item              in_item   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_item;
    logic                  in_taken  = 1'b0;
    int                    sender_pct = 0;
    int                    stall_pct  = 0;
    int                    items_sent = 0;
    int                    cycle_count = 0;
    int                    phase;
    int                    rand_start;
    int                    fail_count;
    int                    outstanding;
    int                    result_count;
    int                    wake_count;
    logic [NUM_TIMERS-1:0] armed;

    delta_list_timer_queue #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    dltq_result_checker #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_in_item      (in_item),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out_item     (out_item),
        .o_fail_count   (fail_count),
        .o_outstanding  (outstanding),
        .o_result_count (result_count),
        .o_wake_count   (wake_count),
        .o_armed        (armed)
    );

    always #5 clk = ~clk;

    always @(posedge clk) in_taken <= in_valid && in_ready;

    always @(negedge clk) out_ready = ($urandom_range(99) >= stall_pct);

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic t_in_item make_item(input logic [1:0] act, input logic [3:0] slot,
                                           input logic [31:0] d, input logic [14:0] pid);
        t_in_item it;
        it.action = act;
        it.timer_slot = slot;
        it.delay_ticks = d;
        it.process_id = pid;
        return it;
    endfunction

    // Called and returns at a falling edge.
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < sender_pct) @(negedge clk);
        in_valid = 1'b1;
        in_item = it;
        do @(negedge clk); while (!in_taken);
        in_valid = 1'b0;
        if (it.action != ACT_UNUSED) items_sent++;
    endtask

    task automatic arm_timer(input logic [3:0] slot, input logic [31:0] d,
                             input logic [14:0] pid);
        send_item(make_item(ACT_ADD, slot, d, pid));
    endtask

    task automatic disarm_timer(input logic [3:0] slot);
        send_item(make_item(ACT_DEL, slot, $urandom, 15'($urandom)));
    endtask

    task automatic tick();
        send_item(make_item(ACT_TICK, 4'($urandom), $urandom, 15'($urandom)));
    endtask

    task automatic wait_drained();
        while (outstanding != 0) @(negedge clk);
    endtask

    task automatic clear_armed();
        for (int s = 0; s < NUM_TIMERS; s++)
            if (armed[s]) disarm_timer(s[3:0]);
    endtask

    // Arm every free slot with one deadline, then tick up to it.
    task automatic fill_and_drain(input int d);
        for (int s = 0; s < NUM_TIMERS; s++)
            if (!armed[s]) arm_timer(s[3:0], d, 15'($urandom));
        repeat (d) tick();
    endtask

    function automatic t_in_item random_item();
        int         roll;
        int         droll;
        int         n;
        logic [3:0] s;
        logic [31:0] d;
        roll = $urandom_range(99);
        s = 4'($urandom_range(15));
        droll = $urandom_range(99);
        if (droll < 4) d = 0;
        else if (droll < 80) d = $urandom_range(12, 1);
        else if (droll < 93) d = $urandom_range(300, 13);
        else d = $urandom;
        if (roll < 45) begin
            if ($urandom_range(9) != 0)
                for (n = 0; n < 12 && armed[s]; n++) s = 4'($urandom_range(15));
            return make_item(ACT_ADD, s, d, 15'($urandom));
        end else if (roll < 65) begin
            if ($urandom_range(3) != 0)
                for (n = 0; n < 12 && !armed[s] && armed != '0; n++)
                    s = 4'($urandom_range(15));
            return make_item(ACT_DEL, s, d, 15'($urandom));
        end else if (roll < 98) begin
            return make_item(ACT_TICK, s, d, 15'($urandom));
        end
        return make_item(ACT_UNUSED, s, d, 15'($urandom));
    endfunction

    initial begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        tick();
        send_item(make_item(ACT_UNUSED, 4'd15, 32'hFFFF_FFFF, 15'h7FFF));
        disarm_timer(4'd5);
        arm_timer(4'd0, 32'd0, 15'h7FFF);
        arm_timer(4'd0, 32'd3, 15'h7FFF);
        arm_timer(4'd0, 32'd0, 15'h0001);
        arm_timer(4'd0, 32'd5, 15'h0000);
        arm_timer(4'd15, 32'hFFFF_FFFF, 15'h0000);
        arm_timer(4'd7, 32'd3, 15'h1234);
        arm_timer(4'd3, 32'd1, 15'h2AAA);
        arm_timer(4'd9, 32'd2, 15'h5555);
        tick();
        disarm_timer(4'd9);
        tick();
        tick();
        disarm_timer(4'd15);
        disarm_timer(4'd15);
        arm_timer(4'd12, 32'd2, 15'h0F0F);
        arm_timer(4'd4, 32'd2, 15'h70F0);
        disarm_timer(4'd12);
        tick();
        tick();
        wait_drained();

        rand_start = items_sent;
        phase = 0;
        clear_armed();
        fill_and_drain(1);
        while (items_sent - rand_start < RANDOM_ITEMS) begin
            case (phase % 4)
                0: begin sender_pct = 0;  stall_pct = 0;  end
                1: begin sender_pct = 75; stall_pct = 0;  end
                2: begin sender_pct = 0;  stall_pct = 75; end
                default: begin sender_pct = 38; stall_pct = 38; end
            endcase
            if ($urandom_range(1) != 0) fill_and_drain($urandom_range(3, 1));
            repeat (35) send_item(random_item());
            wait_drained();
            phase++;
        end

        sender_pct = 0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        $display("Covered %0d add/delete/tick transfers and %0d result transfers (%0d wakeups),",
                 items_sent, result_count, wake_count);
        $display("over %0d random phases of sender gaps and receiver stalls.", phase);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
